// ----- hw/rtl/i2cts_pkg.sv -----
`timescale 1ns / 1ps

package i2cts_pkg;

   // request codes
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_EVENT = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   // buffer select codes
   localparam logic BUF_MASTER = 1'b0;
   localparam logic BUF_SLAVE  = 1'b1;

   // controller event flag positions
   localparam int EV_SB    = 0;
   localparam int EV_ADDR  = 1;
   localparam int EV_TRA   = 2;
   localparam int EV_TXE   = 3;
   localparam int EV_RXNE  = 4;
   localparam int EV_STOPF = 5;
   localparam int EV_MSL   = 6;

   // acknowledge enable levels
   localparam logic ACK_ON  = 1'b1;
   localparam logic ACK_OFF = 1'b0;

   localparam int SLAVE_LENGTH_W = 9;

   typedef logic [SLAVE_LENGTH_W-1:0] csr_type;

   typedef struct packed {
      logic [1:0] action;
      logic       read_not_write;
      logic [6:0] slave_address;
      logic [7:0] byte_count;
      logic [6:0] event_flags;
      logic [4:0] error_flags;
      logic [7:0] data_byte;
      logic       buffer_select;
      logic [7:0] entry_index;
   } req_type;

   typedef struct packed {
      logic       dr_write;
      logic [7:0] dr_value;
      logic       ack_level;
      logic       start_request;
      logic       stop_request;
      logic       tx_done;
      logic       rx_done;
      logic       error_valid;
      logic [4:0] error_bits;
      logic       stop_flag_clear;
      logic       idle;
      logic [7:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic       master_active;
      logic       idle;
      logic       direction;
      logic [6:0] target_address;
      logic [7:0] transfer_length;
      logic [7:0] position;
      logic       ack;
   } state_type;

   // buffer access control from the step logic
   typedef struct packed {
      logic       wr_en;
      logic       wr_sel;
      logic [7:0] wr_addr;
      logic [7:0] wr_data;
      logic [7:0] rd_addr;
      logic       rd_sel;
      logic       dr_from_mem;
      logic       rd_from_mem;
   } mem_ctl_type;

endpackage

// ----- hw/rtl/i2cts_chan_if.sv -----
`timescale 1ns / 1ps

interface i2cts_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/i2cts_ram.sv -----
`timescale 1ns / 1ps

module i2cts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/i2cts_step.sv -----
`timescale 1ns / 1ps

module i2cts_step
   import i2cts_pkg::*;
(
   input  state_type   cur,
   input  req_type     req,
   input  csr_type     slave_length,
   output state_type   nxt,
   output rsp_type     res,
   output mem_ctl_type mem
);
   logic [7:0] pos_inc;
   logic [7:0] len_dec;
   logic [6:0] ev;

   assign pos_inc = 8'(cur.position + 8'd1);
   assign len_dec = 8'(cur.transfer_length - 8'd1);
   assign ev      = req.event_flags;

   // next state and result for one request
   always_comb begin
      nxt = cur;
      res = '0;
      mem = '0;
      mem.wr_addr = req.entry_index;
      mem.wr_data = req.data_byte;
      mem.rd_addr = req.entry_index;
      mem.wr_sel  = req.buffer_select;
      mem.rd_sel  = req.buffer_select;

      case (req.action)
         ACT_START: begin
            if (cur.idle) begin
               nxt.idle            = 1'b0;
               nxt.direction       = req.read_not_write;
               nxt.target_address  = req.slave_address;
               nxt.transfer_length = req.byte_count;
               nxt.position        = '0;
               nxt.master_active   = 1'b1;
               nxt.ack             = ACK_ON;
               res.start_request   = 1'b1;
            end
         end
         ACT_EVENT: begin
            if (cur.master_active) begin
               // bus master sequencing
               if (ev[EV_SB]) begin
                  res.dr_write = 1'b1;
                  res.dr_value = {cur.target_address, cur.direction};
               end else if (ev[EV_ADDR]) begin
                  nxt.position = '0;
               end else if (ev[EV_TRA]) begin
                  if (ev[EV_TXE]) begin
                     res.dr_write    = 1'b1;
                     mem.rd_addr     = cur.position;
                     mem.rd_sel      = BUF_MASTER;
                     mem.dr_from_mem = 1'b1;
                     nxt.position    = pos_inc;
                     if (pos_inc == cur.transfer_length) begin
                        res.stop_request = 1'b1;
                        res.tx_done      = 1'b1;
                        nxt.idle         = 1'b1;
                     end
                  end else begin
                     nxt.idle = 1'b1;
                  end
               end else begin
                  if (ev[EV_RXNE]) begin
                     if (cur.position < cur.transfer_length) begin
                        mem.wr_en   = 1'b1;
                        mem.wr_sel  = BUF_MASTER;
                        mem.wr_addr = cur.position;
                        mem.wr_data = req.data_byte;
                     end
                     if (cur.transfer_length != 8'd0 && cur.position == len_dec) begin
                        nxt.ack          = ACK_OFF;
                        res.stop_request = 1'b1;
                        res.rx_done      = 1'b1;
                        nxt.idle         = 1'b1;
                     end else if (cur.position >= cur.transfer_length) begin
                        nxt.master_active = 1'b0;
                        nxt.ack           = ACK_ON;
                        nxt.idle          = 1'b1;
                     end
                     nxt.position = pos_inc;
                  end else begin
                     nxt.idle = 1'b1;
                  end
               end
            end else begin
               // addressed slave
               if (ev[EV_ADDR]) begin
                  nxt.ack      = ACK_ON;
                  nxt.position = '0;
               end else if (ev[EV_RXNE]) begin
                  if ({1'b0, cur.position} < slave_length) begin
                     mem.wr_en    = 1'b1;
                     mem.wr_sel   = BUF_SLAVE;
                     mem.wr_addr  = cur.position;
                     mem.wr_data  = req.data_byte;
                     nxt.position = pos_inc;
                  end
                  nxt.ack = ACK_ON;
               end else if (ev[EV_TXE]) begin
                  res.dr_write = 1'b1;
                  if ({1'b0, cur.position} < slave_length) begin
                     mem.rd_addr     = cur.position;
                     mem.rd_sel      = BUF_SLAVE;
                     mem.dr_from_mem = 1'b1;
                     nxt.position    = pos_inc;
                  end
               end
            end

            // error report, stop while bus master
            if (req.error_flags != 5'd0) begin
               res.error_valid = 1'b1;
               res.error_bits  = req.error_flags;
               if (ev[EV_MSL]) begin
                  res.stop_request = 1'b1;
               end
            end
            // stop seen: stop flag clear requested, ack drops with it
            if (ev[EV_STOPF]) begin
               res.stop_flag_clear = 1'b1;
               nxt.ack             = ACK_OFF;
            end
         end
         ACT_WRITE: begin
            mem.wr_en = 1'b1;
         end
         default: begin
            mem.rd_from_mem = 1'b1;
         end
      endcase

      res.ack_level = nxt.ack;
      res.idle      = nxt.idle;
   end
endmodule

// ----- hw/rtl/i2c_transaction_sequencer_core.sv -----
`timescale 1ns / 1ps

// I2C transfer sequencer. Takes one request per clock (start, controller event,
// buffer write or buffer read) and returns exactly one result for each, in the
// cycle after acceptance, from a registered output stage; req_chan.ready stays
// high as long as that stage is empty or being taken in the same cycle, so with
// rsp_chan.ready held high the block runs at one request per cycle. The master
// and slave buffers are two single-port-write RAMs with a registered read port;
// the read issued at acceptance lands together with the result, and a write
// is visible to the very next request. Buffer contents are undefined until
// written. The slave length register may be written at any time through
// csr_chan, which is always ready; it takes effect for the next request.
module i2c_transaction_sequencer_core
   import i2cts_pkg::*;
#(
   parameter int BUFFER_DEPTH = 256
) (
   input logic          clock,
   input logic          reset,
   i2cts_chan_if.sink   req_chan,
   i2cts_chan_if.source rsp_chan,
   i2cts_chan_if.sink   csr_chan
);
   localparam int AW = $clog2(BUFFER_DEPTH);

   state_type   state_ff, state_in;
   csr_type     slave_length_ff;
   logic        rsp_valid_ff;
   rsp_type     out_ff, step_res;
   logic        dr_mem_ff, rd_mem_ff, rd_sel_ff;
   mem_ctl_type mem;
   logic        req_fire;
   logic        wr_ok, rd_ok;
   logic [7:0]  master_rdata, slave_rdata, mem_rdata;
   rsp_type     rsp_out;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   i2cts_step u_step (
      .cur          (state_ff),
      .req          (req_chan.payload),
      .slave_length (slave_length_ff),
      .nxt          (state_in),
      .res          (step_res),
      .mem          (mem)
   );

   // entries beyond the buffer depth are not written, and their read data is not used
   assign wr_ok = mem.wr_en && ({1'b0, mem.wr_addr} < 9'(BUFFER_DEPTH));
   assign rd_ok = {1'b0, mem.rd_addr} < 9'(BUFFER_DEPTH);

   i2cts_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_master_ram (
      .clock   (clock),
      .wr_en   (req_fire && wr_ok && mem.wr_sel == BUF_MASTER),
      .wr_addr (mem.wr_addr[AW-1:0]),
      .wr_data (mem.wr_data),
      .rd_en   (req_fire),
      .rd_addr (mem.rd_addr[AW-1:0]),
      .rd_data (master_rdata)
   );

   i2cts_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_slave_ram (
      .clock   (clock),
      .wr_en   (req_fire && wr_ok && mem.wr_sel == BUF_SLAVE),
      .wr_addr (mem.wr_addr[AW-1:0]),
      .wr_data (mem.wr_data),
      .rd_en   (req_fire),
      .rd_addr (mem.rd_addr[AW-1:0]),
      .rd_data (slave_rdata)
   );

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= '{master_active: 1'b0, idle: 1'b1, direction: 1'b0,
                              target_address: '0, transfer_length: '0,
                              position: '0, ack: ACK_OFF};
         slave_length_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         if (csr_chan.valid) begin
            slave_length_ff <= csr_chan.payload;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         out_ff    <= step_res;
         dr_mem_ff <= mem.dr_from_mem && rd_ok;
         rd_mem_ff <= mem.rd_from_mem && rd_ok;
         rd_sel_ff <= mem.rd_sel;
      end
   end

   // merge buffer read data into the result
   assign mem_rdata = (rd_sel_ff == BUF_SLAVE) ? slave_rdata : master_rdata;

   always_comb begin
      rsp_out = out_ff;
      if (dr_mem_ff) begin
         rsp_out.dr_value = mem_rdata;
      end
      rsp_out.read_data = rd_mem_ff ? mem_rdata : 8'd0;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_out;

   // accepted start while idle enters master mode
   a_start_enters_master: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.payload.action == ACT_START && state_ff.idle)
      |=> (!state_ff.idle && state_ff.master_active))
      else $error("start while idle did not enter master mode");

   // error bits only accompany an error report
   a_error_bits_flagged: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_out.error_valid || rsp_out.error_bits == 5'd0))
      else $error("error bits without error report");

   // no transmit byte without a data register write
   a_dr_value_gated: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_out.dr_write) |-> (rsp_out.dr_value == 8'd0))
      else $error("dr_value set without dr_write");

   // a finished transfer always requests stop, and only one direction finishes
   a_done_has_stop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_out.tx_done || rsp_out.rx_done))
      |-> (rsp_out.stop_request && !(rsp_out.tx_done && rsp_out.rx_done)))
      else $error("transfer done without stop request");

   // reported ack level and idle flag match the state left by the request
   a_ack_tracks_state: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_out.ack_level == state_ff.ack && rsp_out.idle == state_ff.idle))
      else $error("reported ack or idle differs from state");
endmodule
